// File: sv/rpi_pkg.sv
// Package for the three-axis rate PI controller: shared types, widths, constants
// and the microprogram ROM that sequences the datapath.
// No dependencies.
`default_nettype none

package rpi_pkg;

  // Geometry
  localparam int AXES   = 3;
  localparam int AXIS_W = 2;
  localparam int PC_W   = 4;

  // Datapath widths
  localparam int ACC_W  = 80;   // accumulator, holds inner*dt exactly
  localparam int TMP_W  = 60;   // diff (Q.34) or inner (Q.34) operand store
  localparam int MA_W   = 33;   // multiplier operand A, signed
  localparam int MB_W   = 17;   // multiplier operand B, zero-extended gain or step time
  localparam int PROD_W = MA_W + MB_W;

  // Fixed-point constants in the accumulator domain
  localparam logic signed [ACC_W-1:0] SAT_POS    = ACC_W'(64'sd17179869184); // 1.0 in Q.34
  localparam logic signed [ACC_W-1:0] SAT_NEG    = -SAT_POS;
  localparam logic signed [ACC_W-1:0] AW_TOL     = ACC_W'(64'sd1717986);     // 1e-4 in Q.34
  localparam logic signed [ACC_W-1:0] RND8_HALF  = ACC_W'(64'sd128);
  localparam logic signed [ACC_W-1:0] RND24_HALF = ACC_W'(64'sd8388608);
  localparam logic signed [35:0]      CMD_HALF   = 36'sd524288;              // Q.34 -> Q1.14

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ROLL_KP  = 3'd0,
    REG_ROLL_KI  = 3'd1,
    REG_PITCH_KP = 3'd2,
    REG_PITCH_KI = 3'd3,
    REG_YAW_KP   = 3'd4,
    REG_YAW_KI   = 3'd5,
    REG_WINDUP   = 3'd6,
    REG_BOUND    = 3'd7
  } reg_idx_t;

  // Multiplier operand A source
  typedef enum logic [2:0] {
    A_ERR   = 3'd0,
    A_INTEG = 3'd1,
    A_TLO25 = 3'd2,
    A_THI25 = 3'd3,
    A_TLO30 = 3'd4,
    A_THI30 = 3'd5
  } a_sel_t;

  // Multiplier operand B source
  typedef enum logic [1:0] {
    B_KP = 2'd0,
    B_KI = 2'd1,
    B_WG = 2'd2,
    B_DT = 2'd3
  } b_sel_t;

  // Accumulator / result operation
  typedef enum logic [2:0] {
    ACC_NOP   = 3'd0,
    ACC_LOAD  = 3'd1,
    ACC_ADD   = 3'd2,
    ACC_SAT   = 3'd3,
    ACC_RND8  = 3'd4,
    ACC_INNER = 3'd5,
    ACC_RND24 = 3'd6,
    ACC_CLAMP = 3'd7
  } acc_op_t;

  // Product alignment into the accumulator
  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_14 = 2'd1,
    SH_25 = 2'd2,
    SH_30 = 2'd3
  } sh_t;

  // Sequencing
  typedef enum logic [1:0] {
    SEQ_NEXT = 2'd0,
    SEQ_AXIS = 2'd1,
    SEQ_DONE = 2'd2
  } seq_t;

  typedef struct packed {
    logic            err_ld;
    logic            mul_en;
    a_sel_t          a_sel;
    b_sel_t          b_sel;
    acc_op_t         acc_op;
    sh_t             sh;
    seq_t            seq;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    ucode_t            uw;
    logic [AXIS_W-1:0] axis;
    logic              start;
  } ctrl_t;

  typedef struct packed {
    logic [AXES-1:0][15:0] kp;
    logic [AXES-1:0][15:0] ki;
    logic [15:0]           wg;
    logic [30:0]           bound;
  } gains_t;

  typedef struct packed {
    logic [AXES-1:0][15:0] rate_ref;
    logic [AXES-1:0][15:0] rate_meas;
    logic [15:0]           dt;
  } sample_t;

  typedef struct packed {
    logic [AXES-1:0][15:0] cmd;
    logic [AXES-1:0][16:0] err;
    logic [AXES-1:0][31:0] integ;
    logic                  flag;
  } result_t;

  localparam ucode_t UW_NOP = '{
    err_ld: 1'b0, mul_en: 1'b0, a_sel: A_ERR, b_sel: B_KP,
    acc_op: ACC_NOP, sh: SH_0, seq: SEQ_NEXT, target: '0
  };

  localparam logic [PC_W-1:0] PC_AXIS_START = 4'd0;

  // Microprogram: steps 0..14 run one axis, step 15 hands the result over
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = UW_NOP;
    unique case (pc)
      4'd0:  w.err_ld = 1'b1;                                   // err = ref - meas
      4'd1:  begin w.mul_en = 1'b1; w.a_sel = A_ERR; w.b_sel = B_KP; end
      4'd2:  begin
        w.mul_en = 1'b1; w.a_sel = A_INTEG; w.b_sel = B_KI;
        w.acc_op = ACC_LOAD; w.sh = SH_14;                      // Kp*err << 14
      end
      4'd3:  begin w.acc_op = ACC_ADD; w.sh = SH_0; end         // + Ki*integ = unsat
      4'd4:  w.acc_op = ACC_SAT;                                // clamp, diff, cmd, flag
      4'd5:  begin w.mul_en = 1'b1; w.a_sel = A_TLO25; w.b_sel = B_WG; end
      4'd6:  begin
        w.mul_en = 1'b1; w.a_sel = A_THI25; w.b_sel = B_WG;
        w.acc_op = ACC_LOAD; w.sh = SH_0;
      end
      4'd7:  begin w.acc_op = ACC_ADD; w.sh = SH_25; end        // Kaw*diff
      4'd8:  w.acc_op = ACC_RND8;
      4'd9:  w.acc_op = ACC_INNER;                              // + err << 22
      4'd10: begin w.mul_en = 1'b1; w.a_sel = A_TLO30; w.b_sel = B_DT; end
      4'd11: begin
        w.mul_en = 1'b1; w.a_sel = A_THI30; w.b_sel = B_DT;
        w.acc_op = ACC_LOAD; w.sh = SH_0;
      end
      4'd12: begin w.acc_op = ACC_ADD; w.sh = SH_30; end        // inner*dt
      4'd13: w.acc_op = ACC_RND24;
      4'd14: begin
        w.acc_op = ACC_CLAMP; w.seq = SEQ_AXIS; w.target = PC_AXIS_START;
      end
      4'd15: w.seq = SEQ_DONE;
      default: w = UW_NOP;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: sv/rpi_seq.sv
// Microcode sequencer: step counter, axis counter and control word fetch.
// Depends on rpi_pkg.
`default_nettype none

module rpi_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic           out_free,
  output rpi_pkg::ctrl_t      ctrl,
  output logic                idle,
  output logic                done
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } st_t;

  st_t                            state, state_next;
  logic [rpi_pkg::PC_W-1:0]       pc, pc_next;
  logic [rpi_pkg::AXIS_W-1:0]     axis, axis_next;
  rpi_pkg::ucode_t                word;
  logic                           run;

  // Control word fetch
  assign word = rpi_pkg::ucode_rom(pc);
  assign run  = (state == ST_RUN);
  assign idle = (state == ST_IDLE);
  assign done = run && (word.seq == rpi_pkg::SEQ_DONE) && out_free;

  assign ctrl.uw    = run ? word : rpi_pkg::UW_NOP;
  assign ctrl.axis  = axis;
  assign ctrl.start = start;

  // Next step
  always_comb begin
    state_next = state;
    pc_next    = pc;
    axis_next  = axis;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
          pc_next    = rpi_pkg::PC_AXIS_START;
          axis_next  = '0;
        end
      end
      ST_RUN: begin
        unique case (word.seq)
          rpi_pkg::SEQ_NEXT: pc_next = pc + 1'b1;
          rpi_pkg::SEQ_AXIS: begin
            if (axis == rpi_pkg::AXIS_W'(rpi_pkg::AXES - 1)) begin
              pc_next = pc + 1'b1;
            end else begin
              axis_next = axis + 1'b1;
              pc_next   = word.target;
            end
          end
          rpi_pkg::SEQ_DONE: begin
            if (out_free) state_next = ST_IDLE;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
      axis  <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      axis  <= axis_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/rpi_dp.sv
// Datapath: shared 33x17 multiplier, 80-bit accumulator, operand store,
// integrator state and per-axis result registers. Driven by rpi_seq.
// Depends on rpi_pkg.
`default_nettype none

module rpi_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rpi_pkg::ctrl_t   ctrl,
  input  wire rpi_pkg::gains_t  gains,
  input  wire rpi_pkg::sample_t sample,
  output rpi_pkg::result_t      res
);

  localparam int ACC_W  = rpi_pkg::ACC_W;
  localparam int TMP_W  = rpi_pkg::TMP_W;
  localparam int MA_W   = rpi_pkg::MA_W;
  localparam int MB_W   = rpi_pkg::MB_W;
  localparam int PROD_W = rpi_pkg::PROD_W;
  localparam int AXES   = rpi_pkg::AXES;

  rpi_pkg::ucode_t uw;
  assign uw = ctrl.uw;

  // Stored values
  logic signed [ACC_W-1:0]  acc;
  logic signed [TMP_W-1:0]  tmp;
  logic signed [PROD_W-1:0] prod;
  logic signed [16:0]       err_r;
  logic signed [31:0]       integ  [AXES];
  logic signed [15:0]       cmd_q  [AXES];
  logic signed [16:0]       err_q  [AXES];
  logic                     flag;

  // Per-axis selection
  logic [15:0]        kp_s, ki_s;
  logic signed [15:0] ref_s, meas_s;
  logic signed [31:0] integ_s;

  always_comb begin
    unique case (ctrl.axis)
      2'd0: begin
        kp_s = gains.kp[0]; ki_s = gains.ki[0];
        ref_s = sample.rate_ref[0]; meas_s = sample.rate_meas[0]; integ_s = integ[0];
      end
      2'd1: begin
        kp_s = gains.kp[1]; ki_s = gains.ki[1];
        ref_s = sample.rate_ref[1]; meas_s = sample.rate_meas[1]; integ_s = integ[1];
      end
      default: begin
        kp_s = gains.kp[2]; ki_s = gains.ki[2];
        ref_s = sample.rate_ref[2]; meas_s = sample.rate_meas[2]; integ_s = integ[2];
      end
    endcase
  end

  logic signed [16:0] err_calc;
  assign err_calc = ref_s - meas_s;

  // Multiplier operands: wide values go through in signed-high / unsigned-low halves
  logic signed [MA_W-1:0]   a_op;
  logic signed [MB_W-1:0]   b_op;
  logic signed [PROD_W-1:0] mul_out;

  always_comb begin
    unique case (uw.a_sel)
      rpi_pkg::A_ERR:   a_op = {{(MA_W-17){err_r[16]}}, err_r};
      rpi_pkg::A_INTEG: a_op = {integ_s[31], integ_s};
      rpi_pkg::A_TLO25: a_op = {{(MA_W-25){1'b0}}, tmp[24:0]};
      rpi_pkg::A_THI25: a_op = {{(MA_W-25){tmp[49]}}, tmp[49:25]};
      rpi_pkg::A_TLO30: a_op = {{(MA_W-30){1'b0}}, tmp[29:0]};
      rpi_pkg::A_THI30: a_op = {{(MA_W-30){tmp[59]}}, tmp[59:30]};
      default:          a_op = '0;
    endcase
    unique case (uw.b_sel)
      rpi_pkg::B_KP: b_op = {1'b0, kp_s};
      rpi_pkg::B_KI: b_op = {1'b0, ki_s};
      rpi_pkg::B_WG: b_op = {1'b0, gains.wg};
      rpi_pkg::B_DT: b_op = {1'b0, sample.dt};
      default:       b_op = '0;
    endcase
  end

  assign mul_out = a_op * b_op;

  // Product alignment
  logic signed [ACC_W-1:0] prod_x, prod_sh;
  assign prod_x = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_comb begin
    unique case (uw.sh)
      rpi_pkg::SH_0:  prod_sh = prod_x;
      rpi_pkg::SH_14: prod_sh = prod_x <<< 14;
      rpi_pkg::SH_25: prod_sh = prod_x <<< 25;
      rpi_pkg::SH_30: prod_sh = prod_x <<< 30;
      default:        prod_sh = prod_x;
    endcase
  end

  // Saturation to +-1.0, difference, command rounding and windup test
  logic signed [ACC_W-1:0] sat, diff;
  logic signed [35:0]      cmd_sum;
  logic signed [15:0]      cmd_calc;
  logic                    clip_hit;

  always_comb begin
    if (acc > rpi_pkg::SAT_POS) begin
      sat = rpi_pkg::SAT_POS;
    end else if (acc < rpi_pkg::SAT_NEG) begin
      sat = rpi_pkg::SAT_NEG;
    end else begin
      sat = acc;
    end
  end

  assign diff     = sat - acc;
  assign cmd_sum  = sat[35:0] + rpi_pkg::CMD_HALF;
  assign cmd_calc = cmd_sum[35:20];
  assign clip_hit = (diff > rpi_pkg::AW_TOL) || (diff < -rpi_pkg::AW_TOL);

  // Rounding shifts, half toward plus infinity
  logic signed [ACC_W-1:0] rnd8, rnd24, rnd8_sum, rnd24_sum;
  assign rnd8_sum  = acc + rpi_pkg::RND8_HALF;
  assign rnd24_sum = acc + rpi_pkg::RND24_HALF;
  assign rnd8      = rnd8_sum >>> 8;
  assign rnd24     = rnd24_sum >>> 24;

  // inner = Kaw*diff + err << 22
  logic signed [ACC_W-1:0] err_x, inner_sum;
  assign err_x     = {{(ACC_W-17){err_r[16]}}, err_r};
  assign inner_sum = acc + (err_x <<< 22);

  // Integrator update and symmetric clamp
  logic signed [ACC_W-1:0] int_sum, bound_p, bound_n, int_clamp;
  assign int_sum = acc + {{(ACC_W-32){integ_s[31]}}, integ_s};
  assign bound_p = {{(ACC_W-31){1'b0}}, gains.bound};
  assign bound_n = -bound_p;

  always_comb begin
    if (int_sum > bound_p) begin
      int_clamp = bound_p;
    end else if (int_sum < bound_n) begin
      int_clamp = bound_n;
    end else begin
      int_clamp = int_sum;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (uw.mul_en) prod <= mul_out;
    if (uw.err_ld) begin
      err_r            <= err_calc;
      err_q[ctrl.axis] <= err_calc;
    end
    unique case (uw.acc_op)
      rpi_pkg::ACC_NOP:   ;
      rpi_pkg::ACC_LOAD:  acc <= prod_sh;
      rpi_pkg::ACC_ADD:   acc <= acc + prod_sh;
      rpi_pkg::ACC_SAT: begin
        tmp              <= diff[TMP_W-1:0];
        cmd_q[ctrl.axis] <= cmd_calc;
      end
      rpi_pkg::ACC_RND8:  acc <= rnd8;
      rpi_pkg::ACC_INNER: tmp <= inner_sum[TMP_W-1:0];
      rpi_pkg::ACC_RND24: acc <= rnd24;
      rpi_pkg::ACC_CLAMP: ;
      default: ;
    endcase
  end

  // Integrator state and windup flag
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) integ[i] <= '0;
      flag <= 1'b0;
    end else begin
      if (ctrl.start) begin
        flag <= 1'b0;
      end else if (uw.acc_op == rpi_pkg::ACC_SAT) begin
        flag <= flag | clip_hit;
      end
      if (uw.acc_op == rpi_pkg::ACC_CLAMP) begin
        integ[ctrl.axis] <= int_clamp[31:0];
      end
    end
  end

  // Result view
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      res.cmd[i]   = cmd_q[i];
      res.err[i]   = err_q[i];
      res.integ[i] = integ[i];
    end
    res.flag = flag;
  end

endmodule

`default_nettype wire

// File: sv/three_axis_rate_pi_controller_unit.sv
// Top level of the three-axis rate PI controller with back-calculation anti-windup.
// Holds the configuration registers, the input sample and the output register.
// Depends on rpi_pkg, rpi_seq and rpi_dp.
//
//   Channel   Direction  Handshake              Payload
//   cfg       in         cfg_we                 cfg_addr (register index), cfg_wdata
//   s_axis    in         s_tvalid / s_tready    s_tdata: refs, measurements, step time
//   m_axis    out        m_tvalid / m_tready    m_tdata: commands, errors, integrators;
//                                               m_tuser: windup flag
//
// A request is taken while the sequencer is idle; the 16-word microprogram then runs
// 15 steps per axis over one shared 33x17 multiplier and accumulator, plus one
// hand-over step that loads the result into the output register; the next request
// is taken only once the sequencer is idle again after the hand-over.
// The hand-over step waits while the output register still holds an untaken result.
// Synchronous reset clears the integrators, gains, bound and all handshake state.
`default_nettype none

module three_axis_rate_pi_controller_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration writes
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [30:0]  cfg_wdata,
  // request side
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [15:0] ref_roll, [31:16] ref_pitch, [47:32] ref_yaw, [63:48] meas_roll,
  // [79:64] meas_pitch, [95:80] meas_yaw, [111:96] step_time
  input  wire logic [111:0] s_tdata,
  // result side
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [15:0] aileron_cmd, [31:16] elevator_cmd, [47:32] rudder_cmd,
  // [64:48] err_roll, [81:65] err_pitch, [98:82] err_yaw,
  // [130:99] next_int_roll, [162:131] next_int_pitch, [194:163] next_int_yaw,
  // [199:195] zero
  output logic [199:0]      m_tdata,
  // [0] windup_flag
  output logic              m_tuser
);

  localparam int AXES = rpi_pkg::AXES;

  // Configuration registers
  rpi_pkg::gains_t gains;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains <= '0;
    end else if (cfg_we) begin
      unique case (rpi_pkg::reg_idx_t'(cfg_addr))
        rpi_pkg::REG_ROLL_KP:  gains.kp[0] <= cfg_wdata[15:0];
        rpi_pkg::REG_ROLL_KI:  gains.ki[0] <= cfg_wdata[15:0];
        rpi_pkg::REG_PITCH_KP: gains.kp[1] <= cfg_wdata[15:0];
        rpi_pkg::REG_PITCH_KI: gains.ki[1] <= cfg_wdata[15:0];
        rpi_pkg::REG_YAW_KP:   gains.kp[2] <= cfg_wdata[15:0];
        rpi_pkg::REG_YAW_KI:   gains.ki[2] <= cfg_wdata[15:0];
        rpi_pkg::REG_WINDUP:   gains.wg    <= cfg_wdata[15:0];
        rpi_pkg::REG_BOUND:    gains.bound <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Request capture
  logic              idle, done, accept, out_free;
  rpi_pkg::sample_t  sample;

  assign s_tready = idle;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < AXES; i++) begin
        sample.rate_ref[i]  <= s_tdata[16*i +: 16];
        sample.rate_meas[i] <= s_tdata[16*(i+AXES) +: 16];
      end
      sample.dt <= s_tdata[111:96];
    end
  end

  // Sequencer and datapath
  rpi_pkg::ctrl_t   ctrl;
  rpi_pkg::result_t res;

  rpi_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .out_free (out_free),
    .ctrl     (ctrl),
    .idle     (idle),
    .done     (done)
  );

  rpi_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .gains  (gains),
    .sample (sample),
    .res    (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {5'b0,
                  res.integ[2], res.integ[1], res.integ[0],
                  res.err[2], res.err[1], res.err[0],
                  res.cmd[2], res.cmd[1], res.cmd[0]};
      m_tuser <= res.flag;
    end
  end

endmodule

`default_nettype wire

// File: sim/rate_pi_checker.sv
// Checker for the three-axis rate PI controller: follows register writes, predicts
// each demand from its request and compares it with what leaves the result channel.
// Depends on rpi_pkg for the register index codes.
`timescale 1ns / 100ps

module rate_pi_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [30:0]  cfg_wdata,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [111:0] s_tdata,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [199:0] m_tdata,
  input  wire logic         m_tuser,
  output int                fails,
  output int                backlog
);

  localparam longint UNIT_Q34 = 64'sd17179869184;  // 1.0
  localparam longint CLIP_TOL = 64'sd1717986;      // 1e-4

  typedef struct packed {
    logic [2:0][15:0] cmd;
    logic [2:0][16:0] err;
    logic [2:0][31:0] integ;
    logic             clip;
  } demand_t;

  // model copy of gains, bound and integrators
  logic [15:0] prop_gain [3];
  logic [15:0] int_gain [3];
  logic [15:0] aw_gain;
  logic [30:0] int_limit;
  longint      integ_acc [3];

  demand_t demand_q [$];
  int      mismatch_count = 0;
  int      queued = 0;

  string cmd_name [3] = '{"aileron_cmd", "elevator_cmd", "rudder_cmd"};
  string err_name [3] = '{"err_roll", "err_pitch", "err_yaw"};
  string int_name [3] = '{"next_int_roll", "next_int_pitch", "next_int_yaw"};

  assign fails   = mismatch_count;
  assign backlog = queued;

  // (a * m) / 2^k rounded half up, exact for the operand sizes used here
  function automatic longint scale_round(input longint a, input longint unsigned m,
                                         input int k);
    longint unsigned lo;
    lo = longint'(a) & ((64'd1 << k) - 64'd1);
    return (a >>> k) * longint'(m) + longint'((lo * m + (64'd1 << (k - 1))) >> k);
  endfunction

  // one axis of the control law; updates the integrator in place
  function automatic void control_axis(input logic signed [15:0] rate_ref,
                                       input logic signed [15:0] rate_meas,
                                       input int ax, input logic [15:0] dt,
                                       output logic [16:0] err_out,
                                       output logic [15:0] cmd_out,
                                       inout logic clip);
    longint err, unsat, sat, diff, inner, nxt, lim;
    err   = longint'(rate_ref) - longint'(rate_meas);
    unsat = err * longint'(prop_gain[ax]) * 16384 + integ_acc[ax] * longint'(int_gain[ax]);
    sat   = unsat;
    if (sat > UNIT_Q34) sat = UNIT_Q34;
    if (sat < -UNIT_Q34) sat = -UNIT_Q34;
    diff = sat - unsat;
    if (diff > CLIP_TOL || diff < -CLIP_TOL) clip = 1'b1;
    // back-calculation term plus error, integrated over the step
    inner = err * (64'sd1 <<< 22) + scale_round(diff, aw_gain, 8);
    nxt   = integ_acc[ax] + scale_round(inner, dt, 24);
    lim   = longint'(int_limit);
    if (nxt > lim) nxt = lim;
    if (nxt < -lim) nxt = -lim;
    integ_acc[ax] = nxt;
    err_out = err[16:0];
    cmd_out = 16'((sat + (64'sd1 <<< 19)) >>> 20);
  endfunction

  function automatic demand_t predict_demand(input logic [111:0] req);
    demand_t d;
    logic    clip;
    clip = 1'b0;
    for (int ax = 0; ax < 3; ax++) begin
      control_axis(req[16*ax +: 16], req[48+16*ax +: 16], ax, req[111:96],
                   d.err[ax], d.cmd[ax], clip);
      d.integ[ax] = integ_acc[ax][31:0];
    end
    d.clip = clip;
    return d;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // sample all channels on the rising edge
  always @(posedge clk) begin : watch
    demand_t want;
    if (rst) begin
      for (int ax = 0; ax < 3; ax++) begin
        prop_gain[ax] = '0;
        int_gain[ax]  = '0;
        integ_acc[ax] = 0;
      end
      aw_gain   = '0;
      int_limit = '0;
      demand_q.delete();
    end else begin
      if (cfg_we) begin
        case (rpi_pkg::reg_idx_t'(cfg_addr))
          rpi_pkg::REG_ROLL_KP:  prop_gain[0] = cfg_wdata[15:0];
          rpi_pkg::REG_ROLL_KI:  int_gain[0]  = cfg_wdata[15:0];
          rpi_pkg::REG_PITCH_KP: prop_gain[1] = cfg_wdata[15:0];
          rpi_pkg::REG_PITCH_KI: int_gain[1]  = cfg_wdata[15:0];
          rpi_pkg::REG_YAW_KP:   prop_gain[2] = cfg_wdata[15:0];
          rpi_pkg::REG_YAW_KI:   int_gain[2]  = cfg_wdata[15:0];
          rpi_pkg::REG_WINDUP:   aw_gain      = cfg_wdata[15:0];
          rpi_pkg::REG_BOUND:    int_limit    = cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) demand_q.push_back(predict_demand(s_tdata));
      if (m_tvalid && m_tready) begin
        if (demand_q.size() == 0) begin
          $error("result with no request outstanding");
          mismatch_count++;
        end else begin
          want = demand_q.pop_front();
          for (int ax = 0; ax < 3; ax++) begin
            check_field(cmd_name[ax], 64'(want.cmd[ax]), 64'(m_tdata[16*ax +: 16]));
            check_field(err_name[ax], 64'(want.err[ax]), 64'(m_tdata[48+17*ax +: 17]));
            check_field(int_name[ax], 64'(want.integ[ax]), 64'(m_tdata[99+32*ax +: 32]));
          end
          check_field("windup_flag", 64'(want.clip), 64'(m_tuser));
          check_field("tdata_pad", 64'd0, 64'(m_tdata[199:195]));
        end
      end
    end
    queued <= demand_q.size();
  end

endmodule

// File: sim/tb.sv
// Testbench top for the three-axis rate PI controller: clock, reset, register
// settings, request stimulus and result back-pressure; rate_pi_checker does the checking.
// Depends on rpi_pkg, rate_pi_checker and three_axis_rate_pi_controller_unit.
`timescale 1ns / 100ps

module tb;

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  rpi_pkg::reg_idx_t cfg_addr = rpi_pkg::REG_ROLL_KP;
  logic [30:0]       cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [111:0]      s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [199:0]      m_tdata;
  logic              m_tuser;
  int                fails;
  int                backlog;

  int                send_idle = 0;
  int                recv_idle = 0;
  int                hold_left = 0;
  logic [30:0]       reg_val [8];

  three_axis_rate_pi_controller_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  rate_pi_checker u_chk (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fails(fails), .backlog(backlog)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // overall time limit
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stalls, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  function automatic logic [111:0] pack_sample(input logic [15:0] r0, r1, r2,
                                               input logic [15:0] m0, m1, m2,
                                               input logic [15:0] dt);
    return {dt, m2, m1, m0, r2, r1, r0};
  endfunction

  // mostly tracking samples (small error), some arbitrary ones
  function automatic logic [111:0] random_sample();
    logic [15:0] r [3];
    logic [15:0] m [3];
    logic [15:0] dt;
    for (int k = 0; k < 3; k++) begin
      r[k] = 16'($urandom);
      if ($urandom_range(0, 9) < 6) m[k] = r[k] + 16'($urandom_range(0, 1024)) - 16'd512;
      else m[k] = 16'($urandom);
    end
    case ($urandom_range(0, 9))
      0:       dt = '0;
      1, 2:    dt = 16'($urandom);
      default: dt = 16'($urandom_range(1, 2000));
    endcase
    return pack_sample(r[0], r[1], r[2], m[0], m[1], m[2], dt);
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(0, 1024));
    endcase
  endfunction

  function automatic logic [30:0] pick_bound();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 31'h7FFF_FFFF;
      2:       return 31'($urandom);
      default: return 31'($urandom_range(0, 1 << 28));
    endcase
  endfunction

  // offer one request, with random idle cycles ahead of it
  task automatic send_sample(input logic [111:0] d);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop offering and wait until every demand has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
  endtask

  // write all registers; gain writes carry random junk above bit 15
  task automatic set_gains(input logic [15:0] kp0, ki0, kp1, ki1, kp2, ki2, wg,
                           input logic [30:0] bound);
    logic [15:0] g [7];
    g = '{kp0, ki0, kp1, ki1, kp2, ki2, wg};
    for (int i = 0; i < 7; i++) reg_val[i] = {15'($urandom), g[i]};
    reg_val[7] = bound;
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= rpi_pkg::reg_idx_t'(i);
      cfg_wdata <= reg_val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: all gains and the bound at zero
    send_idle = 10;
    recv_idle = 20;
    send_sample(pack_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_sample(pack_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF));
    send_sample(pack_sample(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
    drain();

    // unity roll, extreme pitch, tiny yaw gains; widest bound
    set_gains(16'd256, 16'd256, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 16'd256, 31'h7FFF_FFFF);
    send_sample(pack_sample(16'd100, 16'd1, 16'd50, 16'd0, 16'd0, 16'd0, 16'd65));
    // error of exactly 1.0 then just above: clip at the tolerance edge
    send_sample(pack_sample(16'd4096, 16'd0, 16'd4096, 16'd0, 16'd0, 16'd0, 16'd0));
    send_sample(pack_sample(16'd4097, 16'd0, 16'd4097, 16'd0, 16'd0, 16'd0, 16'd0));
    send_sample(pack_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF));
    send_sample(pack_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF));
    // zero step time: integrators only re-clamped
    send_sample(pack_sample(16'h1234, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_sample(pack_sample(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
    send_sample(pack_sample(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
    send_sample(pack_sample(16'h8000, 16'h7FFF, 16'h0001, 16'h8000, 16'h8000, 16'hFFFF, 16'h0001));
    send_sample(pack_sample(16'hFFFF, 16'h0000, 16'h8001, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000));
    send_sample(pack_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    drain();

    // bound of zero holds every integrator at zero
    set_gains(16'd512, 16'd512, 16'd512, 16'd512, 16'd512, 16'd512, 16'hFFFF, 31'd0);
    send_sample(pack_sample(16'h7FFF, 16'h0100, 16'h8000, 16'h8000, 16'h0000, 16'h7FFF, 16'hFFFF));
    send_sample(pack_sample(16'h0010, 16'h0000, 16'hFFF0, 16'h0000, 16'h0010, 16'h0000, 16'h0800));
    drain();

    // every gain at its maximum
    set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF);
    send_sample(pack_sample(16'h7FFF, 16'h8000, 16'h0001, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF));
    send_sample(pack_sample(16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF));
    send_sample(pack_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100));
    drain();

    // random part: eight settings of 100 requests each
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        send_idle = 29;
        recv_idle = 60;
      end else if (ph < 6) begin
        send_idle = 60;
        recv_idle = 29;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (ph == 7)
        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  31'h7FFF_FFFF);
      else
        set_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                  pick_gain(), pick_gain(), pick_bound());
      for (int n = 0; n < 100; n++) begin
        // long result hold-off while requests keep coming
        if (ph == 1 && n == 40) hold_left = 400;
        send_sample(random_sample());
      end
      drain();
    end

    repeat (60) @(posedge clk);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
